/* hw/rtl/crt_pkg.sv */
// ----------------------------------------------------------------------------
// crt_pkg
// Shared widths, status codes, datapath operation codes and link structs.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int W               = 64;
  localparam int IN_W            = 32;
  localparam int OUT_W           = 63;
  localparam int DEF_MOD_BITS    = 32;
  localparam int DEF_RESULT_BITS = 63;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOSOL = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  typedef logic [4:0] op_t;

  localparam op_t OP_LOAD   = 5'd0;
  localparam op_t OP_STICKY = 5'd1;
  localparam op_t OP_NOSOL  = 5'd2;
  localparam op_t OP_OVF    = 5'd3;
  localparam op_t OP_R2     = 5'd4;
  localparam op_t OP_FIRST  = 5'd5;
  localparam op_t OP_GINIT  = 5'd6;
  localparam op_t OP_GCD    = 5'd7;
  localparam op_t OP_RG1    = 5'd8;
  localparam op_t OP_RG2    = 5'd9;
  localparam op_t OP_N      = 5'd10;
  localparam op_t OP_Q      = 5'd11;
  localparam op_t OP_LCM    = 5'd12;
  localparam op_t OP_RM     = 5'd13;
  localparam op_t OP_DG     = 5'd14;
  localparam op_t OP_A1     = 5'd15;
  localparam op_t OP_A2     = 5'd16;
  localparam op_t OP_IINIT  = 5'd17;
  localparam op_t OP_INV    = 5'd18;
  localparam op_t OP_PM     = 5'd19;
  localparam op_t OP_NT     = 5'd20;
  localparam op_t OP_T      = 5'd21;
  localparam op_t OP_P      = 5'd22;
  localparam op_t OP_FIN    = 5'd23;

  typedef struct packed {
    logic start;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic first;
    logic sticky;
    logic m2_zero;
    logic ovf_first;
    logic gb_zero;
    logic mismatch;
    logic ovf;
    logic re_zero;
  } sts_t;

  function automatic logic op_is_div(input op_t op);
    return op inside {OP_R2, OP_GCD, OP_RG1, OP_RG2, OP_N, OP_Q, OP_RM,
                      OP_DG, OP_A1, OP_A2, OP_INV};
  endfunction

  function automatic logic op_is_mul(input op_t op);
    return op inside {OP_LCM, OP_PM, OP_T, OP_P};
  endfunction

  function automatic logic op_is_emit(input op_t op);
    return op inside {OP_STICKY, OP_NOSOL, OP_OVF, OP_FIRST, OP_FIN};
  endfunction

endpackage

/* hw/rtl/crt_congruence_combiner.sv */
// ----------------------------------------------------------------------------
// crt_congruence_combiner
// Folds congruences x = residue (mod modulus) into one running congruence.
// Input words on s_axis: residue and modulus in tdata, a first flag in tuser
// that starts a new system. One output word on m_axis per input word:
// combined residue and lcm in tdata, status in tuser (0 solution,
// 1 no solution, 2 modulus overflow; failures stick until a first word).
// One word is processed at a time. Divisions run through a restoring
// divider and multiplies through a double-and-add modular multiplier.
// A first word takes a single division; a combining word takes 9
// divisions and 3 multiplies, plus one division per gcd step and one
// division and one multiply per inverse step.
// Reset clears the accumulated system to x = 0 (mod 1), status 0.
// The output word is held in a register; while the receiver stalls the
// block finishes the current word and waits before writing the next
// result, with s_axis_tready low until it is written.
// ----------------------------------------------------------------------------
module crt_congruence_combiner import crt_pkg::*; #(
  parameter int MOD_BITS    = DEF_MOD_BITS,
  parameter int RESULT_BITS = DEF_RESULT_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // in_residue[31:0], in_modulus[63:32]
  input  logic [0:0]   s_axis_tuser,  // first[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // out_residue[62:0], out_modulus[125:63], zero pad
  output logic [1:0]   m_axis_tuser   // status[1:0]
);

  cmd_t             cmd;
  sts_t             sts;
  logic [OUT_W-1:0] out_residue, out_modulus;

  crt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  crt_dp #(
    .MOD_BITS   (MOD_BITS),
    .RESULT_BITS(RESULT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_residue (s_axis_tdata[31:0]),
    .in_modulus (s_axis_tdata[63:32]),
    .in_first   (s_axis_tuser[0]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_residue(out_residue),
    .out_modulus(out_modulus),
    .out_status (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, out_modulus, out_residue};

endmodule

/* hw/rtl/crt_div.sv */
// ----------------------------------------------------------------------------
// crt_div
// Restoring divider, one quotient bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module crt_div import crt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dv;
  logic [W:0]    shifted;
  logic          fits;

  assign shifted = {rem, quo[W-1]};
  assign fits    = shifted >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      quo <= {quo[W-2:0], fits};
      rem <= fits ? W'(shifted - {1'b0, dv}) : shifted[W-1:0];
    end
  end

endmodule

/* hw/rtl/crt_mulmod.sv */
// ----------------------------------------------------------------------------
// crt_mulmod
// Modular multiply by double-and-add, one multiplier bit per cycle.
// Operands must already be below the modulus.
// ----------------------------------------------------------------------------
module crt_mulmod import crt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a_in,
  input  logic [W-1:0] b_in,
  input  logic [W-1:0] n_in,
  output logic         done,
  output logic [W-1:0] res
);

  logic         busy;
  logic [W-1:0] a;
  logic [W-1:0] b;
  logic [W-1:0] n;
  logic [W:0]   sum_acc;
  logic [W:0]   sum_dbl;

  assign sum_acc = {1'b0, res} + {1'b0, a};
  assign sum_dbl = {1'b0, a} + {1'b0, a};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && b == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= a_in;
      b   <= b_in;
      n   <= n_in;
      res <= '0;
    end else if (busy && b != '0) begin
      if (b[0]) begin
        res <= (sum_acc >= {1'b0, n}) ? W'(sum_acc - {1'b0, n}) : sum_acc[W-1:0];
      end
      a <= (sum_dbl >= {1'b0, n}) ? W'(sum_dbl - {1'b0, n}) : sum_dbl[W-1:0];
      b <= b >> 1;
    end
  end

endmodule

/* hw/rtl/crt_dp.sv */
// ----------------------------------------------------------------------------
// crt_dp
// Datapath: accumulated congruence, work registers, shared divider and
// modular multiplier, and the output word register.
// ----------------------------------------------------------------------------
module crt_dp import crt_pkg::*; #(
  parameter int MOD_BITS    = DEF_MOD_BITS,
  parameter int RESULT_BITS = DEF_RESULT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [IN_W-1:0]   in_residue,
  input  logic [IN_W-1:0]   in_modulus,
  input  logic              in_first,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_residue,
  output logic [OUT_W-1:0]  out_modulus,
  output logic [1:0]        out_status
);

  localparam logic [W-1:0] IN_MASK = W'((65'd1 << MOD_BITS) - 65'd1);
  localparam logic [W-1:0] RES_MAX = W'((65'd1 << RESULT_BITS) - 65'd1);
  localparam logic [W-1:0] EXACT   = W'(65'd1 << OUT_W);

  logic [W-1:0] acc_r, acc_m;
  logic [1:0]   acc_st;
  logic [W-1:0] rin, m2, r2, ga, gb, tmp, n, q, lcm, diff, av;
  logic [W-1:0] r0, re, t0, t1, pv, tv;
  logic         first, mismatch;

  logic         div_start, div_done, mul_start, mul_done;
  logic [W-1:0] div_num, div_den, quo, rem;
  logic [W-1:0] mul_a, mul_b, mul_n, mres;
  logic         out_free, done;
  logic [W-1:0] diff_sum, nt_sum, q_red;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    if (op_is_div(cmd.op)) begin
      done = div_done;
    end else if (op_is_mul(cmd.op)) begin
      done = mul_done;
    end else if (op_is_emit(cmd.op)) begin
      done = cmd.start && out_free;
    end else begin
      done = cmd.start;
    end
  end

  assign div_start = cmd.start && op_is_div(cmd.op);
  assign mul_start = cmd.start && op_is_mul(cmd.op);

  always_comb begin
    div_num = ga;
    div_den = gb;
    case (cmd.op)
      OP_R2:   begin div_num = rin;     div_den = m2; end
      OP_RG1:  begin div_num = acc_r;   div_den = ga; end
      OP_RG2:  begin div_num = r2;      div_den = ga; end
      OP_N:    begin div_num = m2;      div_den = ga; end
      OP_Q:    begin div_num = RES_MAX; div_den = n;  end
      OP_RM:   begin div_num = acc_r;   div_den = m2; end
      OP_DG:   begin div_num = diff;    div_den = ga; end
      OP_A1:   begin div_num = acc_m;   div_den = ga; end
      OP_A2:   begin div_num = av;      div_den = n;  end
      OP_INV:  begin div_num = r0;      div_den = re; end
      default: begin div_num = ga;      div_den = gb; end
    endcase
  end

  assign q_red = (q >= n) ? q - n : q;

  always_comb begin
    case (cmd.op)
      OP_PM:   begin mul_a = q_red; mul_b = t1; mul_n = n;     end
      OP_T:    begin mul_a = diff;  mul_b = t0; mul_n = n;     end
      OP_P:    begin mul_a = acc_m; mul_b = tv; mul_n = EXACT; end
      default: begin mul_a = acc_m; mul_b = n;  mul_n = EXACT; end
    endcase
  end

  crt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (quo),
    .rem  (rem)
  );

  crt_mulmod u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a_in (mul_a),
    .b_in (mul_b),
    .n_in (mul_n),
    .done (mul_done),
    .res  (mres)
  );

  assign diff_sum = r2 + (m2 - rem);
  assign nt_sum   = t0 + (n - pv);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_r     <= '0;
      acc_m     <= W'(1);
      acc_st    <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (done && op_is_emit(cmd.op)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (done) begin
        case (cmd.op)
          OP_NOSOL: begin
            acc_r  <= '0;
            acc_m  <= W'(1);
            acc_st <= ST_NOSOL;
          end
          OP_OVF: begin
            acc_r  <= '0;
            acc_m  <= W'(1);
            acc_st <= ST_OVF;
          end
          OP_FIRST: begin
            acc_r  <= r2;
            acc_m  <= m2;
            acc_st <= ST_OK;
          end
          OP_FIN: begin
            acc_r  <= acc_r + pv;
            acc_m  <= lcm;
            acc_st <= ST_OK;
          end
          default: ;
        endcase
      end
    end
  end

  // work registers and output word
  always_ff @(posedge clk) begin
    if (done) begin
      case (cmd.op)
        OP_LOAD: begin
          rin   <= W'(in_residue) & IN_MASK;
          m2    <= W'(in_modulus) & IN_MASK;
          first <= in_first;
        end
        OP_STICKY: begin
          out_residue <= '0;
          out_modulus <= '0;
          out_status  <= acc_st;
        end
        OP_NOSOL: begin
          out_residue <= '0;
          out_modulus <= '0;
          out_status  <= ST_NOSOL;
        end
        OP_OVF: begin
          out_residue <= '0;
          out_modulus <= '0;
          out_status  <= ST_OVF;
        end
        OP_R2: r2 <= rem;
        OP_FIRST: begin
          out_residue <= r2[OUT_W-1:0];
          out_modulus <= m2[OUT_W-1:0];
          out_status  <= ST_OK;
        end
        OP_GINIT: begin
          ga <= acc_m;
          gb <= m2;
        end
        OP_GCD: begin
          ga <= gb;
          gb <= rem;
        end
        OP_RG1: tmp <= rem;
        OP_RG2: mismatch <= (rem != tmp);
        OP_N:   n <= quo;
        OP_Q:   q <= quo;
        OP_LCM: lcm <= mres;
        OP_RM:  diff <= (diff_sum >= m2) ? diff_sum - m2 : diff_sum;
        OP_DG:  diff <= quo;
        OP_A1:  av <= quo;
        OP_A2:  av <= rem;
        OP_IINIT: begin
          r0 <= n;
          re <= av;
          t0 <= '0;
          t1 <= W'(1);
        end
        OP_INV: begin
          q   <= quo;
          tmp <= rem;
        end
        OP_PM: pv <= mres;
        OP_NT: begin
          r0 <= re;
          re <= tmp;
          t0 <= t1;
          t1 <= (nt_sum >= n) ? nt_sum - n : nt_sum;
        end
        OP_T: tv <= mres;
        OP_P: pv <= mres;
        OP_FIN: begin
          out_residue <= OUT_W'(acc_r + pv);
          out_modulus <= lcm[OUT_W-1:0];
          out_status  <= ST_OK;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.done      = done;
    sts.first     = first;
    sts.sticky    = acc_st != ST_OK;
    sts.m2_zero   = m2 == '0;
    sts.ovf_first = m2 > RES_MAX;
    sts.gb_zero   = gb == '0;
    sts.mismatch  = mismatch;
    sts.ovf       = acc_m > q;
    sts.re_zero   = re == '0;
  end

endmodule

/* hw/rtl/crt_ctrl.sv */
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer: walks the datapath operations for one input word and
// takes the branches of the gcd and inverse loops.
// ----------------------------------------------------------------------------
module crt_ctrl import crt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  // operation states share the operation codes
  localparam logic [4:0] S_IDLE = 5'd24;
  localparam logic [4:0] S_DEC  = 5'd25;
  localparam logic [4:0] S_GCHK = 5'd26;
  localparam logic [4:0] S_MCHK = 5'd27;
  localparam logic [4:0] S_QCHK = 5'd28;
  localparam logic [4:0] S_ICHK = 5'd29;

  logic [4:0] state, state_next;
  logic       launched, launched_next;
  logic       is_op;

  assign in_ready = (state == S_IDLE) && !rst;
  assign is_op    = state < S_IDLE;

  always_comb begin
    if (state == S_IDLE) begin
      cmd.op    = OP_LOAD;
      cmd.start = in_valid && in_ready;
    end else begin
      cmd.op    = state;
      cmd.start = is_op && !((op_is_div(state) || op_is_mul(state)) && launched);
    end
  end

  always_comb begin
    state_next    = state;
    launched_next = launched;
    if (is_op && cmd.start) begin
      launched_next = 1'b1;
    end
    case (state)
      S_IDLE: if (in_valid) state_next = S_DEC;
      S_DEC: begin
        if (!sts.first && sts.sticky) begin
          state_next = OP_STICKY;
        end else if (sts.m2_zero) begin
          state_next = OP_NOSOL;
        end else begin
          state_next = OP_R2;
        end
      end
      S_GCHK: state_next = sts.gb_zero ? OP_RG1 : OP_GCD;
      S_MCHK: state_next = sts.mismatch ? OP_NOSOL : OP_N;
      S_QCHK: state_next = sts.ovf ? OP_OVF : OP_LCM;
      S_ICHK: state_next = sts.re_zero ? OP_T : OP_INV;
      default: begin
        if (sts.done) begin
          launched_next = 1'b0;
          case (state)
            OP_R2: begin
              if (sts.first) begin
                state_next = sts.ovf_first ? OP_OVF : OP_FIRST;
              end else begin
                state_next = OP_GINIT;
              end
            end
            OP_GINIT: state_next = S_GCHK;
            OP_GCD:   state_next = S_GCHK;
            OP_RG1:   state_next = OP_RG2;
            OP_RG2:   state_next = S_MCHK;
            OP_N:     state_next = OP_Q;
            OP_Q:     state_next = S_QCHK;
            OP_LCM:   state_next = OP_RM;
            OP_RM:    state_next = OP_DG;
            OP_DG:    state_next = OP_A1;
            OP_A1:    state_next = OP_A2;
            OP_A2:    state_next = OP_IINIT;
            OP_IINIT: state_next = S_ICHK;
            OP_INV:   state_next = OP_PM;
            OP_PM:    state_next = OP_NT;
            OP_NT:    state_next = S_ICHK;
            OP_T:     state_next = OP_P;
            OP_P:     state_next = OP_FIN;
            default:  state_next = S_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

endmodule

/* tb/crt_congruence_checker.sv */
// ----------------------------------------------------------------------------
// crt_congruence_checker
// Watches both streams of the congruence combiner. For every word that
// enters, it folds the congruence into its own copy of the running system
// and queues the expected result. Every word that leaves is compared field
// by field against the oldest queued result.
// ----------------------------------------------------------------------------
module crt_congruence_checker import crt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] RES_MAX = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [62:0] residue;
    logic [62:0] modulus;
    logic [1:0]  status;
  } crt_result_t;

  crt_result_t solution_q[$];
  logic [63:0] sys_residue;
  logic [63:0] sys_modulus;
  logic [1:0]  sys_status;

  function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic [63:0] inverse_mod(input logic [63:0] a, input logic [63:0] n);
    logic [127:0] r0, r1, t0, t1, q, nr, nt;
    if (n <= 1) return 0;
    r0 = n;
    r1 = a % n;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      nt = (t0 + n - (q * t1) % n) % n;
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    return t0[63:0];
  endfunction

  function automatic crt_result_t failed(input logic [1:0] st);
    sys_status  = st;
    sys_residue = 0;
    sys_modulus = 1;
    return '{residue: '0, modulus: '0, status: st};
  endfunction

  function automatic crt_result_t fold_congruence(input logic [31:0] res_in,
                                                  input logic [31:0] mod_in,
                                                  input logic is_first);
    logic [63:0]  m1, r1, m2, r2, g, n, diff;
    logic [127:0] t, acc;
    if (!is_first && sys_status != ST_OK)
      return '{residue: '0, modulus: '0, status: sys_status};
    m2 = {32'd0, mod_in};
    if (m2 == 0) return failed(ST_NOSOL);
    r2 = {32'd0, res_in} % m2;
    if (is_first) begin
      sys_residue = r2;
      sys_modulus = m2;
      sys_status  = ST_OK;
      return '{residue: r2[62:0], modulus: m2[62:0], status: ST_OK};
    end
    m1 = sys_modulus;
    r1 = sys_residue;
    g  = gcd64(m1, m2);
    if ((r1 % g) != (r2 % g)) return failed(ST_NOSOL);
    n = m2 / g;
    if (m1 > RES_MAX / n) return failed(ST_OVF);
    diff = ((r2 + m2 - (r1 % m2)) % m2) / g;
    t    = ({64'd0, diff} * inverse_mod((m1 / g) % n, n)) % n;
    acc  = r1 + m1 * t;
    sys_residue = acc[63:0];
    sys_modulus = m1 * n;
    sys_status  = ST_OK;
    return '{residue: sys_residue[62:0], modulus: sys_modulus[62:0], status: ST_OK};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors      = 0;
    sys_residue = 0;
    sys_modulus = 1;
    sys_status  = ST_OK;
  end

  assign pending = solution_q.size();

  always @(posedge clk) begin
    crt_result_t want;
    if (rst) begin
      sys_residue = 0;
      sys_modulus = 1;
      sys_status  = ST_OK;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        solution_q = {solution_q, fold_congruence(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                                  s_axis_tuser[0])};
      if (m_axis_tvalid && m_axis_tready) begin
        if (solution_q.size() == 0) begin
          $display("%0t: result word with nothing expected", $realtime);
          errors++;
        end else begin
          want = solution_q.pop_front();
          if (m_axis_tdata[62:0] != want.residue)
            report_mismatch("residue", 64'(m_axis_tdata[62:0]), 64'(want.residue));
          if (m_axis_tdata[125:63] != want.modulus)
            report_mismatch("modulus", 64'(m_axis_tdata[125:63]), 64'(want.modulus));
          if (m_axis_tuser != want.status)
            report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
          if (m_axis_tdata[127:126] != 2'b00)
            report_mismatch("pad", 64'(m_axis_tdata[127:126]), 64'd0);
        end
      end
    end
  end

endmodule

/* tb/crt_congruence_combiner_tb.sv */
// ----------------------------------------------------------------------------
// crt_congruence_combiner_tb
// Drives congruence systems into the combiner: directed corner words first
// (reset system, extreme fields, zero modulus, conflicts, overflow, sticky
// failures), then random systems built around a hidden solution with some
// noise. Both sides stall at random; one long receiver hold fills the block.
// ----------------------------------------------------------------------------
module crt_congruence_combiner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  int           errors, pending;
  int           send_idle_pct = 30;
  int           recv_idle_pct = 70;
  logic         hold_req = 1'b0;
  logic         holding = 1'b0;

  crt_congruence_combiner dut (.*);

  crt_congruence_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk)
    m_axis_tready <= !holding && ($urandom_range(99) >= recv_idle_pct);

  initial begin
    wait (hold_req);
    @(posedge clk);
    holding <= 1'b1;
    repeat (4000) @(posedge clk);
    holding <= 1'b0;
  end

  task automatic send_word(input logic [31:0] res, input logic [31:0] md, input logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {md, res};
    s_axis_tuser  <= f;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [31:0] pick_modulus();
    int k;
    k = $urandom_range(99);
    if (k < 2) return 32'd0;
    if (k < 60) return $urandom_range(64, 1);
    if (k < 85) return $urandom_range(100000, 1);
    return $urandom;
  endfunction

  initial begin
    logic [63:0] hidden;
    logic [31:0] md, res;
    int          len, sent;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(32'd5, 32'd7, 1'b0);
    send_word(32'd4, 32'd9, 1'b0);
    send_word(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_word(32'hffff_ffff, 32'hffff_fffb, 1'b0);
    send_word(32'd3, 32'd5, 1'b0);
    send_word(32'd0, 32'd1, 1'b1);
    send_word(32'hffff_ffff, 32'd1, 1'b0);
    send_word(32'd1, 32'd4, 1'b0);
    send_word(32'd2, 32'd6, 1'b0);
    send_word(32'd3, 32'd6, 1'b0);
    send_word(32'd9, 32'd0, 1'b1);
    send_word(32'd9, 32'd3, 1'b0);
    send_word(32'd13, 32'd4, 1'b1);
    send_word(32'd3, 32'd6, 1'b0);
    send_word(32'd5, 32'd10, 1'b0);
    send_word(32'd0, 32'd0, 1'b0);
    send_word(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_word(32'h1234_5678, 32'h7fff_ffff, 1'b0);

    sent = 0;
    while (sent < 1150) begin
      if (sent == 380) begin
        send_idle_pct = 70;
        recv_idle_pct = 30;
      end
      if (sent == 760) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
      end
      hidden = {$urandom, $urandom};
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++) begin
        md = pick_modulus();
        if ($urandom_range(99) < 12) res = $urandom;
        else if (md == 0) res = hidden[31:0];
        else begin
          res = 32'(hidden % {32'd0, md});
          if ($urandom_range(9) == 0 && res <= 32'hffff_ffff - md) res = res + md;
        end
        send_word(res, md, (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(29) == 0));
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20000) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("[crt_congruence_combiner] OK");
    else
      $display("[crt_congruence_combiner] ERROR");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("[crt_congruence_combiner] ERROR");
    $finish;
  end

endmodule

/* crt_congruence_combiner.f */
hw/rtl/crt_pkg.sv
hw/rtl/crt_div.sv
hw/rtl/crt_mulmod.sv
hw/rtl/crt_dp.sv
hw/rtl/crt_ctrl.sv
hw/rtl/crt_congruence_combiner.sv
tb/crt_congruence_checker.sv
tb/crt_congruence_combiner_tb.sv
